// ----- design/cpps_pkg.sv -----
// Shared types and constants for the convex polygon plane splitter.
// Used by cpps_dist, cpps_div and convex_polygon_plane_split_core; no dependencies.
`default_nettype none

package cpps_pkg;

   // Vertex store depth and the widths that follow from it.
   localparam int MaxVertices = 16;
   localparam int IdxW        = $clog2(MaxVertices);
   localparam int CntW        = $clog2(MaxVertices + 1);

   // Signed distance width after saturation.
   localparam int DistW = 34;

   // Unit normal component in Q2.14, positive and negative.
   localparam logic signed [15:0] OneQ14    = 16'sd16384;
   localparam logic signed [15:0] NegOneQ14 = -16'sd16384;

   // Configuration register indexes.
   localparam logic [2:0] RegNormalX     = 3'd0;
   localparam logic [2:0] RegNormalY     = 3'd1;
   localparam logic [2:0] RegNormalZ     = 3'd2;
   localparam logic [2:0] RegPlaneOffset = 3'd3;
   localparam logic [2:0] RegEpsilon     = 3'd4;

   // Side of the plane a vertex lies on.
   typedef enum logic [1:0] {
      CLS_FRONT = 2'd0,
      CLS_BACK  = 2'd1,
      CLS_ON    = 2'd2
   } cls_type;

   // Outcome code carried with every result.
   typedef enum logic [1:0] {
      OUT_FRONT    = 2'd0,
      OUT_BACK     = 2'd1,
      OUT_CROSS    = 2'd2,
      OUT_OVERFLOW = 2'd3
   } outcome_type;

   // Distance unit result.
   typedef struct packed {
      logic                    valid;
      logic signed [DistW-1:0] distance;
      cls_type                 cls;
   } dist_res_type;

   // Crossing unit status.
   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

   // One vertex store entry.
   typedef struct packed {
      logic signed [31:0]      x;
      logic signed [31:0]      y;
      logic signed [31:0]      z;
      logic signed [DistW-1:0] distance;
      cls_type                 cls;
   } entry_type;

endpackage

`default_nettype wire

// ----- design/cpps_dist.sv -----
// Three stage signed plane distance and front/back/on classification.
// Depends on cpps_pkg.
`default_nettype none

module cpps_dist (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   start,
   input  wire  signed [31:0]    vx,
   input  wire  signed [31:0]    vy,
   input  wire  signed [31:0]    vz,
   input  wire  signed [15:0]    nx,
   input  wire  signed [15:0]    ny,
   input  wire  signed [15:0]    nz,
   input  wire  signed [31:0]    offset,
   input  wire         [30:0]    eps,
   output cpps_pkg::dist_res_type res
);

   localparam logic signed [36:0] SatMax = 37'sd8589934591;
   localparam logic signed [36:0] SatMin = -37'sd8589934592;

   logic                    v1_ff, v2_ff, v3_ff;
   logic signed [47:0]      px_ff, py_ff, pz_ff;
   logic signed [47:0]      px_in, py_in, pz_in;
   logic signed [49:0]      sum;
   logic signed [36:0]      raw_ff, raw_in;
   logic signed [cpps_pkg::DistW-1:0] d_ff, d_in;
   cpps_pkg::cls_type       cls_ff, cls_in;
   logic signed [34:0]      d_ext, eps_ext;

   // Stage one: the three products.
   assign px_in = nx * vx;
   assign py_in = ny * vy;
   assign pz_in = nz * vz;

   // Stage two: sum, floor by 2^14 and subtract the offset.
   assign sum    = px_ff + py_ff + pz_ff;
   assign raw_in = $signed(sum[49:14]) - offset;

   // Stage three: saturate and classify against the epsilon band.
   always_comb begin
      if (raw_ff > SatMax) begin
         d_in = SatMax[cpps_pkg::DistW-1:0];
      end else if (raw_ff < SatMin) begin
         d_in = SatMin[cpps_pkg::DistW-1:0];
      end else begin
         d_in = raw_ff[cpps_pkg::DistW-1:0];
      end
      d_ext   = {d_in[cpps_pkg::DistW-1], d_in};
      eps_ext = $signed({4'b0000, eps});
      if (d_ext > eps_ext) begin
         cls_in = cpps_pkg::CLS_FRONT;
      end else if (d_ext < -eps_ext) begin
         cls_in = cpps_pkg::CLS_BACK;
      end else begin
         cls_in = cpps_pkg::CLS_ON;
      end
   end

   // Pipeline valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= start;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   // Pipeline payload.
   always_ff @(posedge clock) begin
      px_ff  <= px_in;
      py_ff  <= py_in;
      pz_ff  <= pz_in;
      raw_ff <= raw_in;
      d_ff   <= d_in;
      cls_ff <= cls_in;
   end

   assign res.valid    = v3_ff;
   assign res.distance = d_ff;
   assign res.cls      = cls_ff;

endmodule

`default_nettype wire

// ----- design/cpps_div.sv -----
// Crossing coordinate unit: a + round(|b-a|*|d1|/|d1-d2|) with the sign of b-a.
// Split multiply by halves of |d1|, one quotient bit per cycle, then rounding. Uses cpps_pkg.
`default_nettype none

module cpps_div (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   start,
   input  wire  signed [31:0]    a,
   input  wire  signed [31:0]    b,
   input  wire  signed [cpps_pkg::DistW-1:0] d1,
   input  wire  signed [cpps_pkg::DistW-1:0] d2,
   output cpps_pkg::div_stat_type stat,
   output logic        [31:0]    res
);

   localparam int QuoW = 33;
   localparam int StepW = $clog2(QuoW);

   typedef enum logic [4:0] {
      D_IDLE = 5'b00001,
      D_MUL0 = 5'b00010,
      D_MUL1 = 5'b00100,
      D_DIV  = 5'b01000,
      D_DONE = 5'b10000
   } div_state_type;

   div_state_type       state_ff, state_in;
   logic [StepW-1:0]    step_ff, step_in;
   logic signed [31:0]  a_ff;
   logic                neg_ff;
   logic [32:0]         mdv_ff;
   logic [33:0]         d1m_ff;
   logic [34:0]         den_ff;
   logic [66:0]         prod_ff, prod_in;
   logic [34:0]         rem_ff, rem_in;
   logic [32:0]         lo_ff, lo_in;
   logic signed [32:0]  dv;
   logic signed [34:0]  dd;
   logic [16:0]         mop;
   logic [49:0]         pp;
   logic [35:0]         trial;
   logic                ge;
   logic                up;
   logic [33:0]         q;
   logic [33:0]         sum;

   assign dv = b - a;
   assign dd = d1 - d2;

   // Shared 33x17 multiplier, low half of |d1| first.
   assign mop = state_ff == D_MUL0 ? d1m_ff[16:0] : d1m_ff[33:17];
   assign pp  = mdv_ff * mop;

   // One restoring division step.
   assign trial = {rem_ff, lo_ff[32]};
   assign ge    = trial >= {1'b0, den_ff};

   // Rounding half away from zero and the final add.
   assign up  = {rem_ff, 1'b0} >= {1'b0, den_ff};
   assign q   = {1'b0, lo_ff} + {33'd0, up};
   assign sum = neg_ff ? {{2{a_ff[31]}}, a_ff} - q : {{2{a_ff[31]}}, a_ff} + q;

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      prod_in  = prod_ff;
      rem_in   = rem_ff;
      lo_in    = lo_ff;
      unique case (state_ff)
         D_IDLE: begin
            if (start) begin
               state_in = D_MUL0;
            end
         end
         D_MUL0: begin
            prod_in  = {17'd0, pp};
            state_in = D_MUL1;
         end
         D_MUL1: begin
            prod_in  = prod_ff + {pp, 17'd0};
            rem_in   = {1'b0, prod_in[66:33]};
            lo_in    = prod_in[32:0];
            step_in  = '0;
            state_in = D_DIV;
         end
         D_DIV: begin
            rem_in = ge ? 35'(trial - {1'b0, den_ff}) : trial[34:0];
            lo_in  = {lo_ff[31:0], ge};
            if (step_ff == StepW'(QuoW - 1)) begin
               state_in = D_DONE;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         D_DONE: begin
            state_in = D_IDLE;
         end
         default: begin
            state_in = D_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= D_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Operand capture and working registers.
   always_ff @(posedge clock) begin
      step_ff <= step_in;
      prod_ff <= prod_in;
      rem_ff  <= rem_in;
      lo_ff   <= lo_in;
      if (state_ff == D_IDLE && start) begin
         a_ff   <= a;
         neg_ff <= dv < 0;
         mdv_ff <= dv < 0 ? 33'(-dv) : 33'(dv);
         d1m_ff <= d1 < 0 ? 34'(-d1) : 34'(d1);
         den_ff <= dd < 0 ? 35'(-dd) : 35'(dd);
      end
   end

   assign res       = den_ff == '0 ? a_ff : sum[31:0];
   assign stat.busy = state_ff != D_IDLE;
   assign stat.done = state_ff == D_DONE;

endmodule

`default_nettype wire

// ----- design/convex_polygon_plane_split_core.sv -----
// Top level of the convex polygon plane splitter: vertex store, load and walk sequencer.
// Depends on cpps_pkg, cpps_dist and cpps_div.
//
//   Channel  Direction  Transaction
//   req_     in         one vertex: tdata = x, y, z; tlast = last vertex
//   rsp_     out        one emitted vertex: tdata = x, y, z; tuser = piece, outcome;
//                       tlast = final result of the polygon
//   csr_     in         one register write: index and data
//
// Loading a vertex runs from the accept cycle, which forms the products, through the
// distance pipeline, whose last stage writes the store; the next vertex waits for that write.
// The walk starts with a setup state; then, per vertex, it does two store reads, latches
// both entries, emits its results and steps the index.
// Each crossing edge runs the shared multiply and divide unit once for each of x, y and z.
// Reset is synchronous; the store needs no clearing pass. A stalled rsp_ holds the walk.
`default_nettype none

module convex_polygon_plane_split_core (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [95:0] req_tdata,   // vertex_x, vertex_y, vertex_z
   input  wire         req_tlast,
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [95:0] rsp_tdata,   // out_x, out_y, out_z
   output logic [2:0]  rsp_tuser,   // to_back, outcome
   output logic        rsp_tlast,
   input  wire         csr_valid,
   output logic        csr_ready,
   input  wire  [2:0]  csr_index,
   input  wire  [31:0] csr_data
);

   typedef enum logic [12:0] {
      ST_LOAD    = 13'h0001,
      ST_DIST    = 13'h0002,
      ST_START   = 13'h0004,
      ST_RD_I    = 13'h0008,
      ST_RD_J    = 13'h0010,
      ST_LATCH   = 13'h0020,
      ST_EMIT_V  = 13'h0040,
      ST_EMIT_ON = 13'h0080,
      ST_CX_GO   = 13'h0100,
      ST_CX_WAIT = 13'h0200,
      ST_EMIT_C0 = 13'h0400,
      ST_EMIT_C1 = 13'h0800,
      ST_NEXT    = 13'h1000
   } state_type;

   localparam state_type ST_OVF_UNUSED = ST_LOAD;

   state_type state_ff, state_in;
   logic      ovf_state_ff, ovf_state_in;

   // Configuration registers.
   logic signed [15:0] nx_ff, ny_ff, nz_ff;
   logic signed [31:0] offset_ff;
   logic [30:0]        eps_ff;

   // Polygon bookkeeping.
   logic [cpps_pkg::CntW-1:0] cnt_ff, cnt_in, front_ff, front_in, back_ff, back_in;
   logic                      ovf_ff, ovf_in;
   logic                      last_ff;
   logic signed [31:0]        vx_ff, vy_ff, vz_ff;
   logic [cpps_pkg::IdxW-1:0] idx_ff, idx_in, last_idx, j_idx, rd_addr;
   logic                      uni_ff, uni_in, ub_ff, ub_in;
   logic [1:0]                axis_ff, axis_in;
   logic [31:0]               m_ff [3];
   logic                      is_last_i;

   // Vertex store.
   cpps_pkg::entry_type mem [cpps_pkg::MaxVertices];
   cpps_pkg::entry_type rdata_ff, cur_ff, nxt_ff, wr_entry;
   logic                wr_en;

   // Output register.
   logic        rsp_valid_ff, rsp_valid_in;
   logic [95:0] rsp_data_ff;
   logic [2:0]  rsp_user_ff;
   logic        rsp_last_ff;
   logic        out_free, emit;
   logic [31:0] e_x, e_y, e_z;
   logic        e_back, e_last;
   cpps_pkg::outcome_type e_out;

   // Units.
   logic                   accept;
   cpps_pkg::dist_res_type dres;
   cpps_pkg::div_stat_type dstat;
   logic                   div_start;
   logic signed [31:0]     div_a, div_b;
   logic [31:0]            div_res, cx_val;
   logic signed [15:0]     n_axis;
   logic                   cross_c;

   assign accept     = req_tvalid && req_tready;
   assign req_tready = state_ff == ST_LOAD && !ovf_state_ff;
   assign csr_ready  = 1'b1;

   // Configuration writes; unknown indexes are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         nx_ff     <= cpps_pkg::OneQ14;
         ny_ff     <= '0;
         nz_ff     <= '0;
         offset_ff <= '0;
         eps_ff    <= 31'd26;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            cpps_pkg::RegNormalX:     nx_ff     <= csr_data[15:0];
            cpps_pkg::RegNormalY:     ny_ff     <= csr_data[15:0];
            cpps_pkg::RegNormalZ:     nz_ff     <= csr_data[15:0];
            cpps_pkg::RegPlaneOffset: offset_ff <= csr_data;
            cpps_pkg::RegEpsilon:     eps_ff    <= csr_data[30:0];
            default: begin
            end
         endcase
      end
   end

   cpps_dist u_dist (
      .clock  (clock),
      .reset  (reset),
      .start  (accept),
      .vx     ($signed(req_tdata[31:0])),
      .vy     ($signed(req_tdata[63:32])),
      .vz     ($signed(req_tdata[95:64])),
      .nx     (nx_ff),
      .ny     (ny_ff),
      .nz     (nz_ff),
      .offset (offset_ff),
      .eps    (eps_ff),
      .res    (dres)
   );

   // Axis selection for the crossing unit.
   always_comb begin
      case (axis_ff)
         2'd0: begin
            div_a  = cur_ff.x;
            div_b  = nxt_ff.x;
            n_axis = nx_ff;
         end
         2'd1: begin
            div_a  = cur_ff.y;
            div_b  = nxt_ff.y;
            n_axis = ny_ff;
         end
         default: begin
            div_a  = cur_ff.z;
            div_b  = nxt_ff.z;
            n_axis = nz_ff;
         end
      endcase
   end

   assign div_start = state_ff == ST_CX_GO;

   cpps_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .a     (div_a),
      .b     (div_b),
      .d1    (cur_ff.distance),
      .d2    (nxt_ff.distance),
      .stat  (dstat),
      .res   (div_res)
   );

   // Axis-aligned normals snap the crossing coordinate to the plane offset, negated for -1.0.
   always_comb begin
      if (n_axis == cpps_pkg::OneQ14) begin
         cx_val = offset_ff;
      end else if (n_axis == cpps_pkg::NegOneQ14) begin
         cx_val = 32'(32'd0 - offset_ff);
      end else begin
         cx_val = div_res;
      end
   end

   // Walk indexes.
   assign last_idx  = cpps_pkg::IdxW'(cnt_ff - 1'b1);
   assign is_last_i = idx_ff == last_idx;
   assign j_idx     = is_last_i ? '0 : idx_ff + 1'b1;
   assign rd_addr   = state_ff == ST_RD_I ? idx_ff : j_idx;
   assign cross_c   = cur_ff.cls != cpps_pkg::CLS_ON && nxt_ff.cls != cpps_pkg::CLS_ON
                      && nxt_ff.cls != cur_ff.cls;

   // Store write of a classified vertex.
   assign wr_en = state_ff == ST_DIST && dres.valid
                  && cnt_ff < cpps_pkg::CntW'(cpps_pkg::MaxVertices);
   assign wr_entry.x        = vx_ff;
   assign wr_entry.y        = vy_ff;
   assign wr_entry.z        = vz_ff;
   assign wr_entry.distance = dres.distance;
   assign wr_entry.cls      = dres.cls;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[cnt_ff[cpps_pkg::IdxW-1:0]] <= wr_entry;
      end
      rdata_ff <= mem[rd_addr];
   end

   // Result selection for the current step.
   always_comb begin
      emit   = 1'b0;
      e_x    = cur_ff.x;
      e_y    = cur_ff.y;
      e_z    = cur_ff.z;
      e_back = 1'b0;
      e_out  = cpps_pkg::OUT_CROSS;
      e_last = 1'b0;
      if (ovf_state_ff) begin
         emit   = 1'b1;
         e_x    = '0;
         e_y    = '0;
         e_z    = '0;
         e_out  = cpps_pkg::OUT_OVERFLOW;
         e_last = 1'b1;
      end else begin
         unique case (state_ff)
            ST_EMIT_V: begin
               emit = 1'b1;
               if (uni_ff) begin
                  e_back = ub_ff;
                  e_out  = ub_ff ? cpps_pkg::OUT_BACK : cpps_pkg::OUT_FRONT;
                  e_last = is_last_i;
               end else begin
                  e_back = cur_ff.cls == cpps_pkg::CLS_BACK;
                  e_last = is_last_i && cur_ff.cls != cpps_pkg::CLS_ON && !cross_c;
               end
            end
            ST_EMIT_ON: begin
               emit   = 1'b1;
               e_back = 1'b1;
               e_last = is_last_i;
            end
            ST_EMIT_C0, ST_EMIT_C1: begin
               emit   = 1'b1;
               e_x    = m_ff[0];
               e_y    = m_ff[1];
               e_z    = m_ff[2];
               e_back = state_ff == ST_EMIT_C1;
               e_last = state_ff == ST_EMIT_C1 && is_last_i;
            end
            default: begin
            end
         endcase
      end
   end

   assign out_free     = !rsp_valid_ff || rsp_tready;
   assign rsp_valid_in = (emit && out_free) ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   // Sequencer.
   always_comb begin
      state_in     = state_ff;
      ovf_state_in = ovf_state_ff;
      cnt_in       = cnt_ff;
      front_in     = front_ff;
      back_in      = back_ff;
      ovf_in       = ovf_ff;
      idx_in       = idx_ff;
      uni_in       = uni_ff;
      ub_in        = ub_ff;
      axis_in      = axis_ff;
      if (ovf_state_ff) begin
         if (out_free) begin
            ovf_state_in = 1'b0;
            cnt_in       = '0;
            front_in     = '0;
            back_in      = '0;
            ovf_in       = 1'b0;
         end
      end else begin
         unique case (state_ff)
            ST_LOAD: begin
               if (accept) begin
                  state_in = ST_DIST;
               end
            end
            ST_DIST: begin
               if (dres.valid) begin
                  if (wr_en) begin
                     cnt_in = cnt_ff + 1'b1;
                     if (dres.cls == cpps_pkg::CLS_FRONT) begin
                        front_in = front_ff + 1'b1;
                     end
                     if (dres.cls == cpps_pkg::CLS_BACK) begin
                        back_in = back_ff + 1'b1;
                     end
                  end else begin
                     ovf_in = 1'b1;
                  end
                  state_in = last_ff ? ST_START : ST_LOAD;
               end
            end
            ST_START: begin
               idx_in = '0;
               uni_in = front_ff == '0 || back_ff == '0;
               ub_in  = front_ff == '0;
               if (ovf_ff) begin
                  ovf_state_in = 1'b1;
                  state_in     = ST_LOAD;
               end else begin
                  state_in = ST_RD_I;
               end
            end
            ST_RD_I: begin
               state_in = ST_RD_J;
            end
            ST_RD_J: begin
               state_in = ST_LATCH;
            end
            ST_LATCH: begin
               state_in = ST_EMIT_V;
            end
            ST_EMIT_V: begin
               if (out_free) begin
                  axis_in = 2'd0;
                  if (uni_ff) begin
                     state_in = ST_NEXT;
                  end else if (cur_ff.cls == cpps_pkg::CLS_ON) begin
                     state_in = ST_EMIT_ON;
                  end else if (cross_c) begin
                     state_in = ST_CX_GO;
                  end else begin
                     state_in = ST_NEXT;
                  end
               end
            end
            ST_EMIT_ON: begin
               if (out_free) begin
                  state_in = ST_NEXT;
               end
            end
            ST_CX_GO: begin
               state_in = ST_CX_WAIT;
            end
            ST_CX_WAIT: begin
               if (dstat.done) begin
                  if (axis_ff == 2'd2) begin
                     state_in = ST_EMIT_C0;
                  end else begin
                     axis_in  = axis_ff + 1'b1;
                     state_in = ST_CX_GO;
                  end
               end
            end
            ST_EMIT_C0: begin
               if (out_free) begin
                  state_in = ST_EMIT_C1;
               end
            end
            ST_EMIT_C1: begin
               if (out_free) begin
                  state_in = ST_NEXT;
               end
            end
            ST_NEXT: begin
               if (is_last_i) begin
                  cnt_in   = '0;
                  front_in = '0;
                  back_in  = '0;
                  ovf_in   = 1'b0;
                  state_in = ST_LOAD;
               end else begin
                  idx_in   = idx_ff + 1'b1;
                  state_in = ST_RD_I;
               end
            end
            default: begin
               state_in = ST_OVF_UNUSED;
            end
         endcase
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         ovf_state_ff <= 1'b0;
         cnt_ff       <= '0;
         front_ff     <= '0;
         back_ff      <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ovf_state_ff <= ovf_state_in;
         cnt_ff       <= cnt_in;
         front_ff     <= front_in;
         back_ff      <= back_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      idx_ff  <= idx_in;
      uni_ff  <= uni_in;
      ub_ff   <= ub_in;
      axis_ff <= axis_in;
      if (accept) begin
         vx_ff   <= $signed(req_tdata[31:0]);
         vy_ff   <= $signed(req_tdata[63:32]);
         vz_ff   <= $signed(req_tdata[95:64]);
         last_ff <= req_tlast;
      end
      if (state_ff == ST_RD_J) begin
         cur_ff <= rdata_ff;
      end
      if (state_ff == ST_LATCH) begin
         nxt_ff <= rdata_ff;
      end
      if (state_ff == ST_CX_WAIT && dstat.done) begin
         m_ff[axis_ff] <= cx_val;
      end
      if (emit && out_free) begin
         rsp_data_ff <= {e_z, e_y, e_x};
         rsp_user_ff <= {e_out, e_back};
         rsp_last_ff <= e_last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;

   // The vertex count never passes the store depth.
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= cpps_pkg::CntW'(cpps_pkg::MaxVertices))
      else $error("vertex count above store depth");

   // Front and back vertices are a subset of the stored ones.
   a_side_counts: assert property (@(posedge clock) disable iff (reset)
      ({1'b0, front_ff} + {1'b0, back_ff}) <= {1'b0, cnt_ff})
      else $error("side counts exceed vertex count");

   // The crossing unit is only started when idle.
   a_div_idle: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !dstat.busy)
      else $error("crossing unit started while busy");

   // An overflow result is always the only and final result.
   a_ovf_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[2:1] == cpps_pkg::OUT_OVERFLOW) |-> rsp_tlast)
      else $error("overflow result without last mark");

endmodule

`default_nettype wire

// ----- tb/sv/tb_convex_polygon_plane_split_core.sv -----
// Testbench for convex_polygon_plane_split_core: polygons of fixed point vertices are
// streamed in and every emitted split vertex is checked against an in-bench predictor.
// Depends on cpps_pkg and the core RTL only.
`timescale 1ns / 100ps

module tb_convex_polygon_plane_split_core;

   localparam int MaxMismatchReports = 10;
   localparam longint CycleLimit     = 3000000;
   localparam longint DistHi         = 64'sd8589934591;
   localparam longint DistLo         = -64'sd8589934592;

   // One input vertex and one split result.
   typedef struct {
      logic signed [31:0] x, y, z;
      logic               last_vertex;
   } vertex_type;

   typedef struct {
      logic [31:0]            x, y, z;
      logic                   to_back;
      cpps_pkg::outcome_type  outcome;
      logic                   last_result;
   } split_type;

   // Directed stimulus row; a typed expectation is used when has_exp is set.
   typedef struct {
      vertex_type  v;
      logic        has_exp;
      split_type   e;
   } row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [95:0] req_tdata = '0;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [95:0] rsp_tdata;
   logic [2:0]  rsp_tuser;
   logic        rsp_tlast;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = '0;
   logic [31:0] csr_data = '0;

   convex_polygon_plane_split_core u_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always #5 clock = ~clock;

   // Predictor copy of the plane and the polygon being loaded.
   longint plane_nx, plane_ny, plane_nz, plane_off, plane_eps;
   longint poly_x[cpps_pkg::MaxVertices], poly_y[cpps_pkg::MaxVertices];
   longint poly_z[cpps_pkg::MaxVertices];
   longint poly_d[cpps_pkg::MaxVertices];
   cpps_pkg::cls_type poly_c[cpps_pkg::MaxVertices];
   int     poly_n, poly_front, poly_back;
   bit     poly_overflow;

   split_type pending_splits[$];
   int        mismatch_count = 0;
   int        results_seen = 0;
   int        items_sent = 0;
   int        polygons_sent = 0;
   int        crossing_seen = 0;
   longint    cycle_count = 0;
   bit        rsp_hold = 1'b0;
   int        ready_gap = 0;
   int        ready_seen = 0;

   // Crossing coordinate: a + round(|dv|*|d1|/|d1-d2|) with dv's sign, half away from zero.
   function automatic longint edge_point(longint a, longint b, longint d1, longint d2);
      logic [127:0] num, den, q, r;
      longint dv;
      dv = b - a;
      if (d1 == d2) return a;
      num = 128'((dv < 0) ? -dv : dv) * 128'((d1 < 0) ? -d1 : d1);
      den = 128'((d1 - d2 < 0) ? d2 - d1 : d1 - d2);
      q = num / den;
      r = num % den;
      if (r >= den - r) q = q + 1;
      return (dv < 0) ? a - longint'(q[63:0]) : a + longint'(q[63:0]);
   endfunction

   function automatic longint snap_coord(longint n, longint a, longint b, longint d1,
                                         longint d2);
      if (n == 16384) return plane_off;
      if (n == -16384) return longint'(32'(-plane_off));
      return edge_point(a, b, d1, d2);
   endfunction

   function automatic void push_split(longint x, longint y, longint z, logic back,
                                      cpps_pkg::outcome_type oc);
      split_type s;
      s.x = x[31:0]; s.y = y[31:0]; s.z = z[31:0];
      s.to_back = back; s.outcome = oc; s.last_result = 1'b0;
      pending_splits = {pending_splits, s};
   endfunction

   // Load one vertex into the predictor; at the last vertex queue the whole split.
   function automatic void predict_vertex(vertex_type v);
      longint acc, d;
      int     first, j;
      cpps_pkg::cls_type c;
      first = pending_splits.size();
      if (poly_n < cpps_pkg::MaxVertices) begin
         acc = plane_nx * longint'(v.x) + plane_ny * longint'(v.y) + plane_nz * longint'(v.z);
         d = (acc >>> 14) - plane_off;
         if (d > DistHi) d = DistHi;
         if (d < DistLo) d = DistLo;
         if (d > plane_eps) begin
            c = cpps_pkg::CLS_FRONT; poly_front++;
         end else if (d < -plane_eps) begin
            c = cpps_pkg::CLS_BACK; poly_back++;
         end else begin
            c = cpps_pkg::CLS_ON;
         end
         poly_x[poly_n] = v.x; poly_y[poly_n] = v.y; poly_z[poly_n] = v.z;
         poly_d[poly_n] = d; poly_c[poly_n] = c;
         poly_n++;
      end else begin
         poly_overflow = 1'b1;
      end
      if (!v.last_vertex) return;
      if (poly_overflow) begin
         push_split(0, 0, 0, 1'b0, cpps_pkg::OUT_OVERFLOW);
      end else if (poly_front == 0 || poly_back == 0) begin
         for (int i = 0; i < poly_n; i++)
            push_split(poly_x[i], poly_y[i], poly_z[i], poly_front == 0,
                       poly_front == 0 ? cpps_pkg::OUT_BACK : cpps_pkg::OUT_FRONT);
      end else begin
         for (int i = 0; i < poly_n; i++) begin
            j = (i + 1 == poly_n) ? 0 : i + 1;
            if (poly_c[i] == cpps_pkg::CLS_ON) begin
               push_split(poly_x[i], poly_y[i], poly_z[i], 1'b0, cpps_pkg::OUT_CROSS);
               push_split(poly_x[i], poly_y[i], poly_z[i], 1'b1, cpps_pkg::OUT_CROSS);
               continue;
            end
            push_split(poly_x[i], poly_y[i], poly_z[i], poly_c[i] == cpps_pkg::CLS_BACK,
                       cpps_pkg::OUT_CROSS);
            if (poly_c[j] == cpps_pkg::CLS_ON || poly_c[j] == poly_c[i]) continue;
            for (int s = 0; s < 2; s++)
               push_split(snap_coord(plane_nx, poly_x[i], poly_x[j], poly_d[i], poly_d[j]),
                          snap_coord(plane_ny, poly_y[i], poly_y[j], poly_d[i], poly_d[j]),
                          snap_coord(plane_nz, poly_z[i], poly_z[j], poly_d[i], poly_d[j]),
                          s[0], cpps_pkg::OUT_CROSS);
         end
      end
      if (pending_splits.size() > first)
         pending_splits[pending_splits.size() - 1].last_result = 1'b1;
      poly_n = 0; poly_front = 0; poly_back = 0; poly_overflow = 1'b0;
   endfunction

   // Register write through the configuration channel, mirrored in the predictor.
   task automatic write_reg(logic [2:0] idx, logic [31:0] value);
      @(negedge clock);
      csr_valid <= 1'b1; csr_index <= idx; csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
      case (idx)
         cpps_pkg::RegNormalX:     plane_nx = longint'(signed'(value[15:0]));
         cpps_pkg::RegNormalY:     plane_ny = longint'(signed'(value[15:0]));
         cpps_pkg::RegNormalZ:     plane_nz = longint'(signed'(value[15:0]));
         cpps_pkg::RegPlaneOffset: plane_off = longint'(signed'(value));
         cpps_pkg::RegEpsilon:     plane_eps = longint'(value[30:0]);
         default: ;
      endcase
   endtask

   task automatic set_plane(logic [15:0] nx, logic [15:0] ny, logic [15:0] nz,
                            logic [31:0] off, logic [31:0] eps);
      write_reg(cpps_pkg::RegNormalX, {16'h0, nx});
      write_reg(cpps_pkg::RegNormalY, {16'h0, ny});
      write_reg(cpps_pkg::RegNormalZ, {16'h0, nz});
      write_reg(cpps_pkg::RegPlaneOffset, off);
      write_reg(cpps_pkg::RegEpsilon, eps);
   endtask

   // Send one vertex transaction after a random gap; the predictor sees it on acceptance.
   // Valid stays up after acceptance until the next call or a drain takes it down.
   task automatic send_vertex(vertex_type v);
      int gap;
      gap = $urandom_range(0, 3);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {v.z, v.y, v.x};
      req_tlast  <= v.last_vertex;
      do @(posedge clock); while (!req_tready);
      predict_vertex(v);
      items_sent++;
      if (v.last_vertex) polygons_sent++;
      @(negedge clock);
   endtask

   // Wait until the split of every sent polygon has arrived, plus a settling margin.
   task automatic drain_splits();
      req_tvalid <= 1'b0;
      while (pending_splits.size() != 0) @(negedge clock);
      repeat (200) @(negedge clock);
   endtask

   // Random coordinate: mostly moderate, sometimes the extremes.
   function automatic logic signed [31:0] rand_coord();
      case ($urandom_range(0, 9))
         0: return 32'sh7FFFFFFF;
         1: return 32'sh80000000;
         2: return 32'($urandom);
         default: return 32'(signed'($urandom_range(0, 40000)) - 20000);
      endcase
   endfunction

   task automatic send_polygon(int count);
      vertex_type v;
      for (int i = 0; i < count; i++) begin
         v.x = rand_coord(); v.y = rand_coord(); v.z = rand_coord();
         v.last_vertex = (i == count - 1);
         send_vertex(v);
      end
   endtask

   // Receiver: a random wait before each result, or a long hold when asked.
   always @(negedge clock) begin
      if (results_seen != ready_seen) begin
         ready_seen = results_seen;
         ready_gap  = $urandom_range(0, 3);
      end
      if (reset || rsp_hold) begin
         rsp_tready <= 1'b0;
      end else if (ready_gap > 0) begin
         rsp_tready <= 1'b0;
         ready_gap--;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Result checker at the rising edge.
   always @(posedge clock) begin
      split_type e;
      split_type a;
      if (!reset && rsp_tvalid && rsp_tready) begin
         a.x = rsp_tdata[31:0]; a.y = rsp_tdata[63:32]; a.z = rsp_tdata[95:64];
         a.to_back = rsp_tuser[0]; a.outcome = cpps_pkg::outcome_type'(rsp_tuser[2:1]);
         a.last_result = rsp_tlast;
         results_seen++;
         if (a.outcome == cpps_pkg::OUT_CROSS) crossing_seen++;
         if (pending_splits.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MaxMismatchReports)
               $display("Unexpected result x=%h y=%h z=%h user=%b last=%b",
                        a.x, a.y, a.z, rsp_tuser, a.last_result);
         end else begin
            e = pending_splits.pop_front();
            if (a.x !== e.x || a.y !== e.y || a.z !== e.z || a.to_back !== e.to_back ||
                a.outcome !== e.outcome || a.last_result !== e.last_result) begin
               mismatch_count++;
               if (mismatch_count <= MaxMismatchReports)
                  $display({"Mismatch: exp x=%h y=%h z=%h back=%b oc=%0d last=%b",
                            " / got x=%h y=%h z=%h back=%b oc=%0d last=%b"},
                           e.x, e.y, e.z, e.to_back, e.outcome, e.last_result,
                           a.x, a.y, a.z, a.to_back, a.outcome, a.last_result);
            end
         end
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("Timeout after %0d cycles", cycle_count);
         $display("Test completed with failures");
         $finish;
      end
   end

   // Directed rows: extremes, single and double vertex polygons, a triangle, all on, crossings.
   row_type directed_rows[$];

   function automatic row_type mk(longint x, longint y, longint z, logic lst, logic he,
                                  cpps_pkg::outcome_type oc, logic back);
      row_type r;
      r.v.x = x[31:0]; r.v.y = y[31:0]; r.v.z = z[31:0]; r.v.last_vertex = lst;
      r.has_exp = he;
      r.e.x = x[31:0]; r.e.y = y[31:0]; r.e.z = z[31:0];
      r.e.to_back = back; r.e.outcome = oc; r.e.last_result = 1'b1;
      return r;
   endfunction

   function automatic void add_row(row_type r);
      directed_rows = {directed_rows, r};
   endfunction

   initial begin
      int         n_poly;
      plane_nx = 16384; plane_ny = 0; plane_nz = 0; plane_off = 0; plane_eps = 26;
      poly_n = 0; poly_front = 0; poly_back = 0; poly_overflow = 1'b0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset plane x = 0: single vertices read straight off the register defaults.
      add_row(mk(32'sh7FFFFFFF, 0, 0, 1'b1, 1'b1, cpps_pkg::OUT_FRONT, 1'b0));
      add_row(mk(-64'sh80000000, 5, 5, 1'b1, 1'b1, cpps_pkg::OUT_BACK, 1'b1));
      add_row(mk(26, -1, 1, 1'b1, 1'b1, cpps_pkg::OUT_BACK, 1'b1));
      add_row(mk(27, 0, 0, 1'b1, 1'b1, cpps_pkg::OUT_FRONT, 1'b0));
      add_row(mk(-27, 0, 0, 1'b1, 1'b1, cpps_pkg::OUT_BACK, 1'b1));
      // Two vertex crossing, snapped x.
      add_row(mk(1000, 300, -7, 1'b0, 1'b0, cpps_pkg::OUT_CROSS, 1'b0));
      add_row(mk(-3000, -900, 77, 1'b1, 1'b0, cpps_pkg::OUT_CROSS, 1'b0));
      // Triangle with an on vertex and a crossing edge.
      add_row(mk(0, 100, 0, 1'b0, 1'b0, cpps_pkg::OUT_CROSS, 1'b0));
      add_row(mk(512, 0, 0, 1'b0, 1'b0, cpps_pkg::OUT_CROSS, 1'b0));
      add_row(mk(-512, -100, 9, 1'b1, 1'b0, cpps_pkg::OUT_CROSS, 1'b0));
      // All on polygon.
      add_row(mk(3, 1, 1, 1'b0, 1'b0, cpps_pkg::OUT_BACK, 1'b1));
      add_row(mk(-3, 2, 2, 1'b1, 1'b0, cpps_pkg::OUT_BACK, 1'b1));

      foreach (directed_rows[i]) begin
         send_vertex(directed_rows[i].v);
         if (directed_rows[i].has_exp) begin
            // The typed row must agree with what the predictor queued.
            if (pending_splits.size() == 0 ||
                pending_splits[pending_splits.size() - 1] != directed_rows[i].e) begin
               mismatch_count++;
               $display("Directed row %0d disagrees with its typed expectation", i);
            end
         end
      end

      // Overflow: seventeen vertices in one polygon.
      send_polygon(cpps_pkg::MaxVertices + 1);
      drain_splits();

      // Tilted plane with offset and epsilon at extremes, then a fixed general plane.
      set_plane(16'hC000, 16'h4000, 16'h0000, 32'h80000000, 32'h7FFFFFFF);
      send_polygon(3);
      drain_splits();
      set_plane(16'h2000, 16'hE000, 16'h1234, 32'h7FFFFFFF, 32'h0);
      send_polygon(4);
      drain_splits();

      // Back pressure: hold the receiver while a full polygon plus more are offered.
      fork
         begin
            rsp_hold = 1'b1;
            repeat (3000) @(negedge clock);
            rsp_hold = 1'b0;
         end
         begin
            send_polygon(cpps_pkg::MaxVertices);
            send_polygon(5);
         end
      join
      drain_splits();

      // Random phases: new plane, then polygons of mostly small sizes.
      while (items_sent < 235) begin
         case ($urandom_range(0, 3))
            0: set_plane(16'h4000, 16'h0, 16'hC000, $urandom_range(0, 4000) - 2000,
                         $urandom_range(0, 100));
            1: set_plane(16'($urandom_range(0, 32768) - 16384),
                         16'($urandom_range(0, 32768) - 16384),
                         16'($urandom_range(0, 32768) - 16384),
                         $urandom_range(0, 4000) - 2000, $urandom_range(0, 300));
            2: set_plane(16'h0, 16'h4000, 16'h0, $urandom, $urandom_range(0, 50));
            default: set_plane(16'($urandom), 16'($urandom), 16'($urandom), $urandom,
                               $urandom);
         endcase
         repeat ($urandom_range(2, 6)) begin
            n_poly = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 18)
                                                  : $urandom_range(1, 6);
            send_polygon(n_poly);
         end
         drain_splits();
      end

      drain_splits();
      $display("Sent %0d vertices in %0d polygons across several plane settings;",
               items_sent, polygons_sent);
      $display("checked %0d split results, %0d of them from crossing polygons.",
               results_seen, crossing_seen);
      if (mismatch_count == 0 && pending_splits.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Mismatches: %0d, still expected: %0d", mismatch_count,
                  pending_splits.size());
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
